### rtl/rtr_pkg.sv
// ----------------------------------------------------------------------------
// rtr_pkg
// Types and constants shared by the TCP receive reassembly core.
// ----------------------------------------------------------------------------
package rtr_pkg;

	localparam int RTR_PADDR_W = 3;
	localparam int RTR_DATA_W  = 32;

	// Register index, taken from paddr[2].
	localparam logic RTR_REG_INITIAL_SEQ = 1'b0;

	typedef struct packed {
		logic [31:0] segment_seq;
		logic [7:0]  payload_byte;
		logic        last_in_segment;
		logic        no_payload;
	} rtr_in_t;

	typedef struct packed {
		logic [31:0] ack_number;
		logic        dropped;
	} rtr_out_t;

endpackage

### rtl/rtr_store.sv
// ----------------------------------------------------------------------------
// rtr_store
// Reassembly buffer: one received flag and one payload byte per position,
// one write port and one registered read port for the received flag.
// ----------------------------------------------------------------------------
module rtr_store #(
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic                     wr_seen,
	input  logic [7:0]               wr_byte,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic                     rd_seen_q
);

	logic [8:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_seen, wr_byte};
		end
		if (rd_en) begin
			rd_seen_q <= mem_q[rd_addr][8];
		end
	end

endmodule

### rtl/tcp_receive_reassembly_core.sv
// ----------------------------------------------------------------------------
// tcp_receive_reassembly_core
// Receive-side TCP reassembly into a fixed buffer with a cumulative ACK.
// ----------------------------------------------------------------------------
// Payload bytes enter one per item on the in channel (in_valid, in_stall,
// in_data) with the sequence number of their segment. Each byte is written
// to the buffer at its offset from initial_seq plus one; bytes that fall
// outside the buffer are dropped and flagged. The item marked last in its
// segment yields one result on the out channel (out_valid, out_stall,
// out_data) carrying the new acknowledgement number.
// An item is accepted in ST_IDLE and written to the buffer memory in ST_PROC.
// On the last item the acknowledgement walk then reads the received flags
// through the single read port, passing through ST_WRD and ST_WCHK for each
// newly acknowledged byte until a flag is clear or the walk reaches the end
// of the buffer, and ST_DONE then loads the output register.
// After reset the received flags are cleared by a pass over every buffer
// position during which in_stall stays high; configuration writes are taken.
// A result waiting under out_stall does not block the next items; only a
// second result waits until the first has been taken.
// initial_seq is written over the APB port and also loads the ACK point.
// ----------------------------------------------------------------------------
module tcp_receive_reassembly_core #(
	parameter int BUFFER_DEPTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  rtr_pkg::rtr_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output rtr_pkg::rtr_out_t                    out_data,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rtr_pkg::RTR_PADDR_W-1:0]      paddr,
	input  logic [rtr_pkg::RTR_DATA_W-1:0]       pwdata,
	output logic [rtr_pkg::RTR_DATA_W-1:0]       prdata,
	output logic                                 pready
);

	localparam int          AW      = $clog2(BUFFER_DEPTH);
	localparam logic [31:0] DEPTH_W = 32'(BUFFER_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_PROC  = 3'd2;
	localparam logic [2:0] ST_WRD   = 3'd3;
	localparam logic [2:0] ST_WCHK  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_addr_q;
	logic [31:0]       init_q;
	logic [31:0]       ack_q;
	logic [15:0]       seg_off_q;
	logic              drop_q;
	logic              res_drop_q;
	logic              out_valid_q;
	rtr_pkg::rtr_out_t out_data_q;
	rtr_pkg::rtr_in_t  item_s1;

	logic [31:0]   pos;
	logic          pos_ok;
	logic [31:0]   walk_pos;
	logic          walk_ok;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic          rd_seen_q;
	logic          cfg_wr;
	logic          accept;
	logic          out_free;

	assign pos      = item_s1.segment_seq - init_q - 32'd1 + {16'd0, seg_off_q};
	assign pos_ok   = pos < DEPTH_W;
	assign walk_pos = ack_q - init_q - 32'd1;
	assign walk_ok  = walk_pos < DEPTH_W;

	assign wr_en   = (state_q == ST_CLEAR) ||
	                 ((state_q == ST_PROC) && !item_s1.no_payload && pos_ok);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_addr_q : pos[AW-1:0];
	assign rd_en   = (state_q == ST_WRD) && walk_ok;

	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == rtr_pkg::RTR_REG_INITIAL_SEQ);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == rtr_pkg::RTR_REG_INITIAL_SEQ) ? init_q : '0;

	rtr_store #(
		.DEPTH (BUFFER_DEPTH)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_seen   (state_q != ST_CLEAR),
		.wr_byte   (item_s1.payload_byte),
		.rd_en     (rd_en),
		.rd_addr   (walk_pos[AW-1:0]),
		.rd_seen_q (rd_seen_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			init_q      <= '0;
			ack_q       <= '0;
			seg_off_q   <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				init_q <= pwdata;
				ack_q  <= pwdata + 32'd1;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PROC;
					end
				end
				ST_PROC: begin
					if (!item_s1.no_payload) begin
						seg_off_q <= seg_off_q + 16'd1;
						if (!pos_ok) begin
							drop_q <= 1'b1;
						end
					end
					if (item_s1.last_in_segment) begin
						seg_off_q <= '0;
						drop_q    <= 1'b0;
						state_q   <= ST_WRD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_WRD: begin
					state_q <= walk_ok ? ST_WCHK : ST_DONE;
				end
				ST_WCHK: begin
					if (rd_seen_q) begin
						ack_q   <= ack_q + 32'd1;
						state_q <= ST_WRD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		if ((state_q == ST_PROC) && item_s1.last_in_segment) begin
			res_drop_q <= drop_q || (!item_s1.no_payload && !pos_ok);
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_data_q.ack_number <= ack_q;
			out_data_q.dropped    <= res_drop_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_walk_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WCHK) && rd_seen_q |=> ack_q == $past(ack_q) + 32'd1)
		else $error("ack point did not advance over a received byte");

	a_write_only_store_or_clear: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_PROC) || (state_q == ST_CLEAR))
		else $error("buffer written outside a store or clearing cycle");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
		else $error("clearing pass entered again after it finished");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && !out_free |=> (state_q == ST_DONE))
		else $error("result left the sequencer while the output was still held");
`endif

endmodule
